// ===== src/sorted_breakpoint_interval_search_unit_assert.svh =====
// Assertion macros for the breakpoint interval search unit.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef SORTED_BREAKPOINT_INTERVAL_SEARCH_UNIT_ASSERT_SVH
`define SORTED_BREAKPOINT_INTERVAL_SEARCH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked property, held off while reset is high.
`define SBIS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, also sampled during reset.
`define SBIS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBIS_ASSERT(label, clk, rst, prop, msg)
`define SBIS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== src/sbis_pkg.sv =====
// Shared types and constants for the breakpoint interval search unit.
// No dependencies; used by sbis_ram and the top level.
package sbis_pkg;

  localparam int MAX_POINTS = 256;
  localparam int DATA_W     = 32;
  localparam int COUNT_W    = 9;
  localparam int TOL_W      = 31;
  localparam int PIDX_W     = 8;
  localparam int OUT_IDX_W  = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_FIND    = 2'd2,
    OP_SPACING = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_COUNT = 1'b0,
    CFG_SPACING_TOL = 1'b1
  } cfg_reg_t;

endpackage

// ===== src/sbis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on sbis_pkg for default width and depth.
module sbis_ram #(
  parameter int WIDTH = sbis_pkg::DATA_W,
  parameter int DEPTH = sbis_pkg::MAX_POINTS,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sorted_breakpoint_interval_search_unit.sv =====
// Breakpoint table with interval search, signed Q16.16.
// Depends on sbis_pkg, sbis_ram and sorted_breakpoint_interval_search_unit_assert.svh.
`include "sorted_breakpoint_interval_search_unit_assert.svh"

// The unit keeps up to MAX_POINTS breakpoints (x, y) in two RAMs and serves one
// operation per input beat, returning exactly one result beat. A write shows its
// result the cycle after it is taken; a read returns the RAM data from S_READ. A
// find tests the first segment, then the last, each via S_SEG_LEFT, S_SEG_RIGHT
// and S_SEG_EVAL, then bisects, forming each midpoint in S_MID and testing that
// segment. A spacing check walks the x entries via S_SP_RD, S_SP_GAP and S_SP_CHK,
// stopping at the first gap out of tolerance. Both are paced by the x RAM's single
// read port and the one shared 34-bit subtractor used for segment compares, gaps
// and gap deviations. The unit takes no new beat until the current one has its
// result and the output register is free or being emptied.
module sorted_breakpoint_interval_search_unit #(
  parameter int MAX_POINTS = sbis_pkg::MAX_POINTS
) (
  input  logic                              clk,
  input  logic                              rst,
  // input beats
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        operation,
  input  logic [sbis_pkg::PIDX_W-1:0]       point_index,
  input  logic signed [sbis_pkg::DATA_W-1:0] x_value,
  input  logic signed [sbis_pkg::DATA_W-1:0] y_value,
  // result beats
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [sbis_pkg::DATA_W-1:0] read_x,
  output logic signed [sbis_pkg::DATA_W-1:0] read_y,
  output logic [sbis_pkg::OUT_IDX_W-1:0]    interval_index,
  output logic                              found,
  output logic                              equally_spaced,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbis_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = sbis_pkg::COUNT_W;
  localparam int DW  = sbis_pkg::DATA_W;
  localparam int CAP = (MAX_POINTS < 511) ? MAX_POINTS : 511;
  localparam logic [CW-1:0] CAP_N = CW'(CAP);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SEG_LEFT,
    S_SEG_RIGHT,
    S_SEG_EVAL,
    S_MID,
    S_SP_RD,
    S_SP_GAP,
    S_SP_CHK
  } state_t;

  typedef enum logic [1:0] {
    P_FIRST,
    P_LAST,
    P_SEARCH
  } phase_t;

  state_t state;
  phase_t phase;

  logic [CW-1:0]               point_count;
  logic [sbis_pkg::TOL_W-1:0]  spacing_tolerance;

  logic signed [DW-1:0] query;
  logic [CW-1:0]        seg_i;
  logic [CW-1:0]        lo;
  logic [CW-1:0]        hi;
  logic [CW-1:0]        sp_i;
  logic                 left_le;
  logic                 left_gt;
  logic                 rd_ok;
  logic [DW-1:0]        prev;
  logic signed [DW:0]   gap;
  logic signed [DW:0]   first_gap;

  logic [CW-1:0] live_n;
  logic          accept;
  logic          pidx_ok;
  logic          we;
  logic [CW-1:0] rd_idx;
  logic [DW-1:0] x_rdata;
  logic [DW-1:0] y_rdata;

  logic signed [DW:0]   sub_a;
  logic signed [DW:0]   sub_b;
  logic [DW+1:0]        sub_y;
  logic                 sub_neg;
  logic                 sub_le;
  logic [DW+1:0]        dev_abs;
  logic                 exceeds;

  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic [CW:0]   mid_inc;
  logic          mid_stop;
  logic          hit;

  logic                          done;
  logic [DW-1:0]                 res_rx;
  logic [DW-1:0]                 res_ry;
  logic [sbis_pkg::OUT_IDX_W-1:0] res_idx;
  logic                          res_found;
  logic                          res_eq;

  assign live_n    = (point_count > CAP_N) ? CAP_N : point_count;
  assign in_stall  = !((state == S_IDLE) && (!out_valid || !out_stall));
  assign accept    = in_valid && !in_stall;
  assign pidx_ok   = int'(point_index) < MAX_POINTS;
  assign we        = accept && (operation == sbis_pkg::OP_WRITE) && pidx_ok;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count       <= '0;
      spacing_tolerance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sbis_pkg::CFG_POINT_COUNT: point_count       <= cfg_data[CW-1:0];
        sbis_pkg::CFG_SPACING_TOL: spacing_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (state)
      S_SEG_LEFT:  rd_idx = seg_i;
      S_SEG_RIGHT: rd_idx = seg_i + CW'(1);
      S_SP_RD:     rd_idx = sp_i;
      default:     rd_idx = CW'(point_index);
    endcase
  end

  sbis_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(point_index)),
    .wdata (x_value),
    .raddr (AW'(rd_idx)),
    .rdata (x_rdata)
  );

  sbis_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(point_index)),
    .wdata (y_value),
    .raddr (AW'(rd_idx)),
    .rdata (y_rdata)
  );

  // shared subtractor: segment compares, gap and gap deviation
  always_comb begin
    case (state)
      S_SP_GAP: begin
        sub_a = {x_rdata[DW-1], x_rdata};
        sub_b = {prev[DW-1], prev};
      end
      S_SP_CHK: begin
        sub_a = gap;
        sub_b = first_gap;
      end
      default: begin
        sub_a = {x_rdata[DW-1], x_rdata};
        sub_b = {query[DW-1], query};
      end
    endcase
  end

  assign sub_y   = {sub_a[DW], sub_a} - {sub_b[DW], sub_b};
  assign sub_neg = sub_y[DW+1];
  assign sub_le  = sub_neg || (sub_y == '0);
  assign dev_abs = sub_neg ? ((DW+2)'(0) - sub_y) : sub_y;
  assign exceeds = dev_abs > {3'b000, spacing_tolerance};

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[CW:1];
  assign mid_inc  = {1'b0, mid} + (CW+1)'(1);
  assign mid_stop = (lo >= hi) || (mid_inc >= {1'b0, live_n});
  assign hit      = left_le && !sub_neg;

  // result of the beat in flight, when it completes this cycle
  always_comb begin
    done      = 1'b0;
    res_rx    = '0;
    res_ry    = '0;
    res_idx   = '0;
    res_found = 1'b0;
    res_eq    = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (operation)
            sbis_pkg::OP_WRITE: done = 1'b1;
            sbis_pkg::OP_FIND: done = (live_n < CW'(2));
            sbis_pkg::OP_SPACING: begin
              done   = (live_n <= CW'(2));
              res_eq = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        done   = 1'b1;
        res_rx = rd_ok ? x_rdata : '0;
        res_ry = rd_ok ? y_rdata : '0;
      end
      S_SEG_EVAL: begin
        if (hit) begin
          done      = 1'b1;
          res_found = 1'b1;
          res_idx   = seg_i[sbis_pkg::OUT_IDX_W-1:0];
        end else if (phase == P_SEARCH && !left_gt && seg_i == lo) begin
          done = 1'b1;
        end
      end
      S_MID: done = mid_stop;
      S_SP_CHK: begin
        if (sp_i != CW'(1) && exceeds) begin
          done = 1'b1;
        end else if (sp_i == live_n - CW'(1)) begin
          done   = 1'b1;
          res_eq = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= P_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (done) begin
        out_valid      <= 1'b1;
        read_x         <= res_rx;
        read_y         <= res_ry;
        interval_index <= res_idx;
        found          <= res_found;
        equally_spaced <= res_eq;
        state          <= S_IDLE;
      end else begin
        if (out_valid && !out_stall) begin
          out_valid <= 1'b0;
        end
        case (state)
          S_IDLE: begin
            if (accept) begin
              query <= x_value;
              rd_ok <= pidx_ok;
              case (operation)
                sbis_pkg::OP_READ: state <= S_READ;
                sbis_pkg::OP_FIND: begin
                  seg_i <= '0;
                  phase <= P_FIRST;
                  state <= S_SEG_LEFT;
                end
                sbis_pkg::OP_SPACING: begin
                  sp_i  <= '0;
                  state <= S_SP_RD;
                end
                default: ;
              endcase
            end
          end
          S_SEG_LEFT: state <= S_SEG_RIGHT;
          S_SEG_RIGHT: begin
            // left breakpoint is on the read port now
            left_le <= sub_le;
            left_gt <= !sub_le;
            state   <= S_SEG_EVAL;
          end
          S_SEG_EVAL: begin
            case (phase)
              P_FIRST: begin
                seg_i <= live_n - CW'(2);
                phase <= P_LAST;
                state <= S_SEG_LEFT;
              end
              P_LAST: begin
                lo    <= '0;
                hi    <= live_n;
                phase <= P_SEARCH;
                state <= S_MID;
              end
              default: begin
                if (left_gt) begin
                  hi <= seg_i;
                end else begin
                  lo <= seg_i;
                end
                state <= S_MID;
              end
            endcase
          end
          S_MID: begin
            seg_i <= mid;
            state <= S_SEG_LEFT;
          end
          S_SP_RD: state <= S_SP_GAP;
          S_SP_GAP: begin
            prev <= x_rdata;
            if (sp_i == '0) begin
              sp_i  <= CW'(1);
              state <= S_SP_RD;
            end else begin
              gap   <= sub_y[DW:0];
              state <= S_SP_CHK;
            end
          end
          S_SP_CHK: begin
            if (sp_i == CW'(1)) begin
              first_gap <= gap;
            end
            sp_i  <= sp_i + CW'(1);
            state <= S_SP_RD;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  `SBIS_ASSERT(a_busy_no_result, clk, rst, (state != S_IDLE) |-> !out_valid, "result shown while busy")
  `SBIS_ASSERT(a_search_bounds, clk, rst, (state == S_MID) |-> (lo <= hi), "search range inverted")
  `SBIS_ASSERT(a_probe_in_range, clk, rst, (phase == P_SEARCH && state == S_SEG_LEFT) |-> (seg_i < hi), "probe outside search range")
  `SBIS_ASSERT(a_find_result_clean, clk, rst, (out_valid && found) |-> (read_x == '0 && read_y == '0 && !equally_spaced), "find result carries stray fields")
  `SBIS_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == S_IDLE && !out_valid), "not idle after reset")

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for sorted_breakpoint_interval_search_unit: loads breakpoint tables,
// then checks reads, interval finds and spacing checks against an in-bench table predictor.
// Depends on sbis_pkg and the unit's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_POINTS = sbis_pkg::MAX_POINTS;
  localparam int DATA_W     = sbis_pkg::DATA_W;
  localparam int COUNT_W    = sbis_pkg::COUNT_W;
  localparam int TOL_W      = sbis_pkg::TOL_W;
  localparam int PIDX_W     = sbis_pkg::PIDX_W;
  localparam int OUT_IDX_W  = sbis_pkg::OUT_IDX_W;
  localparam int CFG_IDX_W  = sbis_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = sbis_pkg::CFG_DATA_W;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;
  localparam logic signed [DATA_W-1:0] X_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] X_MAX = 32'sh7fff_ffff;
  localparam logic [TOL_W-1:0] TOL_MAX = '1;

  typedef struct packed {
    logic signed [DATA_W-1:0] rx;
    logic signed [DATA_W-1:0] ry;
    logic [OUT_IDX_W-1:0]     seg;
    logic                     hit;
    logic                     even;
  } lookup_result_t;

  typedef enum int {SHAPE_SORTED, SHAPE_EVEN, SHAPE_FLAT, SHAPE_SHUFFLED} table_shape_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = '0;
  logic [PIDX_W-1:0] point_index = '0;
  logic signed [DATA_W-1:0] x_value = '0;
  logic signed [DATA_W-1:0] y_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] read_x;
  logic signed [DATA_W-1:0] read_y;
  logic [OUT_IDX_W-1:0] interval_index;
  logic found;
  logic equally_spaced;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sorted_breakpoint_interval_search_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .point_index(point_index), .x_value(x_value), .y_value(y_value),
    .out_valid(out_valid), .out_stall(out_stall), .read_x(read_x), .read_y(read_y),
    .interval_index(interval_index), .found(found), .equally_spaced(equally_spaced),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted table and register copies
  logic signed [DATA_W-1:0] x_tbl [MAX_POINTS];
  logic signed [DATA_W-1:0] y_tbl [MAX_POINTS];
  bit entry_written [MAX_POINTS];
  logic [COUNT_W-1:0] count_reg = '0;
  logic [TOL_W-1:0] tol_reg = '0;

  lookup_result_t pending_results [$];
  lookup_result_t head;
  int error_count = 0;
  int beats_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holdoff_req = 0;
  int holdoff_left = 0;
  int quiet_cycles = 0;

  function automatic int live_points();
    return (count_reg > MAX_POINTS) ? MAX_POINTS : int'(count_reg);
  endfunction

  function automatic longint x_at(int i);
    return (i >= 0 && i < MAX_POINTS) ? longint'(x_tbl[i]) : 0;
  endfunction

  function automatic bit spans(int i, longint q);
    return x_at(i) <= q && x_at(i + 1) >= q;
  endfunction

  // First segment, last segment, then bisect; give up once the range stops shrinking.
  function automatic bit locate_segment(longint q, output int seg);
    int n, lo, hi, mid;
    n = live_points();
    seg = 0;
    if (n < 2) return 1'b0;
    if (spans(0, q)) return 1'b1;
    if (spans(n - 2, q)) begin
      seg = n - 2;
      return 1'b1;
    end
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (mid + 1 >= n) return 1'b0;
      if (spans(mid, q)) begin
        seg = mid;
        return 1'b1;
      end
      if (x_at(mid) > q) begin
        hi = mid;
      end else begin
        if (mid == lo) return 1'b0;
        lo = mid;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit gaps_even();
    int n;
    longint first, gap, dev;
    n = live_points();
    if (n <= 2) return 1'b1;
    first = x_at(1) - x_at(0);
    for (int i = 2; i < n; i++) begin
      gap = x_at(i) - x_at(i - 1);
      dev = gap - first;
      if (dev < 0) dev = -dev;
      if (dev > longint'(tol_reg)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic lookup_result_t predict_beat(sbis_pkg::op_t op, logic [PIDX_W-1:0] idx,
                                                  logic signed [DATA_W-1:0] xv,
                                                  logic signed [DATA_W-1:0] yv);
    lookup_result_t r;
    int seg;
    r = '0;
    case (op)
      sbis_pkg::OP_WRITE: begin
        x_tbl[idx] = xv;
        y_tbl[idx] = yv;
        entry_written[idx] = 1'b1;
      end
      sbis_pkg::OP_READ: begin
        r.rx = x_tbl[idx];
        r.ry = y_tbl[idx];
      end
      sbis_pkg::OP_FIND: begin
        r.hit = locate_segment(longint'(xv), seg);
        r.seg = r.hit ? seg[OUT_IDX_W-1:0] : '0;
      end
      default: r.even = gaps_even();
    endcase
    return r;
  endfunction

  function automatic bit table_ready();
    for (int i = 0; i < live_points(); i++)
      if (!entry_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_word(longint v);
    if (v < longint'(X_MIN)) return X_MIN;
    if (v > longint'(X_MAX)) return X_MAX;
    return v[DATA_W-1:0];
  endfunction

  function automatic logic [PIDX_W-1:0] pick_written_index();
    int n, idx;
    n = live_points();
    if (n > 0 && $urandom_range(1) == 1 && table_ready()) return $urandom_range(n - 1);
    repeat (32) begin
      idx = $urandom_range(MAX_POINTS - 1);
      if (entry_written[idx]) return idx;
    end
    for (idx = 0; idx < MAX_POINTS; idx++)
      if (entry_written[idx]) return idx;
    return '0;
  endfunction

  // Queries on breakpoints, between neighbors, just outside the table, at the extremes, or random
  function automatic logic signed [DATA_W-1:0] pick_query();
    int n, last, i, nxt;
    longint q;
    n = live_points();
    last = (n > 0) ? n - 1 : 0;
    i = $urandom_range(last);
    nxt = (i < last) ? i + 1 : i;
    case ($urandom_range(7))
      0, 1:    q = x_at(i);
      2, 3:    q = (x_at(i) + x_at(nxt)) / 2;
      4:       q = x_at(0) - 1 - $urandom_range(1000);
      5:       q = x_at(last) + 1 + $urandom_range(1000);
      6:       q = $urandom_range(1) ? longint'(X_MIN) : longint'(X_MAX);
      default: q = longint'(signed'($urandom));
    endcase
    return clamp_word(q);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] count_word(int n);
    logic [CFG_DATA_W-1:0] w;
    w = $urandom;
    w[COUNT_W-1:0] = n[COUNT_W-1:0];
    return w;
  endfunction

  task automatic send_beat(sbis_pkg::op_t op, logic [PIDX_W-1:0] idx,
                           logic signed [DATA_W-1:0] xv, logic signed [DATA_W-1:0] yv);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    point_index <= idx;
    x_value <= xv;
    y_value <= yv;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_beat(op, idx, xv, yv));
    beats_sent++;
  endtask

  // Drop valid and wait for every outstanding result beat
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(sbis_pkg::cfg_reg_t which, logic [CFG_DATA_W-1:0] data);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (which == sbis_pkg::CFG_POINT_COUNT) count_reg = data[COUNT_W-1:0];
    else tol_reg = data[TOL_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_table(int n, table_shape_t shape, output longint jitter);
    int vals [$];
    longint span, gap, slack, base, v;
    int w;
    jitter = 0;
    if (shape == SHAPE_EVEN && n > 1) begin
      span = longint'(32'hffff_ffff) / (n - 1);
      gap = $urandom_range(1) ? longint'($urandom_range(1, 1000)) : 1 + longint'($urandom) % span;
      if (gap > span) gap = span;
      if ($urandom_range(2) != 0) jitter = $urandom_range(0, gap / 4);
      slack = longint'(32'hffff_ffff) - gap * (n - 1);
      base = longint'(X_MIN) + longint'($urandom) % (slack + 1);
      for (int i = 0; i < n; i++) begin
        v = base + gap * i + longint'($urandom_range(0, 2 * jitter)) - jitter;
        vals.push_back(clamp_word(v));
      end
    end else if (shape == SHAPE_FLAT) begin
      w = $urandom;
      repeat (n) vals.push_back(w);
    end else begin
      repeat (n) vals.push_back($urandom);
      if (shape != SHAPE_SHUFFLED) begin
        vals.sort();
        if (n >= 2 && $urandom_range(3) == 0) begin
          vals[0] = X_MIN;
          vals[n - 1] = X_MAX;
        end
      end
    end
    for (int i = 0; i < n; i++) send_beat(sbis_pkg::OP_WRITE, i, vals[i], $urandom);
  endtask

  task automatic pick_tolerance(longint jitter);
    logic [TOL_W-1:0] t;
    case ($urandom_range(4))
      0:       t = '0;
      1:       t = TOL_MAX;
      2:       t = 2 * jitter;
      3:       t = jitter;
      default: t = $urandom;
    endcase
    write_register(sbis_pkg::CFG_SPACING_TOL, t);
  endtask

  task automatic random_op();
    int n, pick, idx;
    n = live_points();
    pick = $urandom_range(99);
    if (pick < 12) begin
      // writes inside the live range may break the ordering on purpose
      idx = (n > 0 && $urandom_range(1) == 1) ? $urandom_range(n - 1) : $urandom_range(255);
      send_beat(sbis_pkg::OP_WRITE, idx, $urandom, $urandom);
    end else if (pick < 32 || !table_ready()) begin
      send_beat(sbis_pkg::OP_READ, pick_written_index(), $urandom, $urandom);
    end else if (pick < 85) begin
      send_beat(sbis_pkg::OP_FIND, $urandom, pick_query(), $urandom);
    end else begin
      send_beat(sbis_pkg::OP_SPACING, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic run_scenario(int n, int ops);
    table_shape_t shape;
    longint jitter;
    int pick;
    pick = $urandom_range(99);
    shape = (pick < 40) ? SHAPE_SORTED : (pick < 75) ? SHAPE_EVEN :
            (pick < 82) ? SHAPE_FLAT : SHAPE_SHUFFLED;
    load_table(n, shape, jitter);
    if (shape == SHAPE_EVEN || $urandom_range(2) == 0) pick_tolerance(jitter);
    write_register(sbis_pkg::CFG_POINT_COUNT, count_word(n));
    repeat (ops) random_op();
  endtask

  task automatic test_directed();
    send_beat(sbis_pkg::OP_FIND, 8'd0, 32'sd0, 32'sd0);
    send_beat(sbis_pkg::OP_SPACING, 8'd0, 32'sd0, 32'sd0);
    send_beat(sbis_pkg::OP_WRITE, 8'd0, X_MIN, X_MAX);
    send_beat(sbis_pkg::OP_WRITE, 8'd1, 32'sd0, X_MIN);
    send_beat(sbis_pkg::OP_WRITE, 8'd2, X_MAX, 32'sd0);
    send_beat(sbis_pkg::OP_WRITE, 8'd255, 32'sh5555_5555, 32'shaaaa_aaaa);
    send_beat(sbis_pkg::OP_READ, 8'd0, 32'sd0, 32'sd0);
    send_beat(sbis_pkg::OP_READ, 8'd255, 32'sd0, 32'sd0);
    send_beat(sbis_pkg::OP_READ, 8'd2, 32'sd0, 32'sd0);
    // single point: nothing to search, spacing trivially even
    write_register(sbis_pkg::CFG_POINT_COUNT, 31'd1);
    send_beat(sbis_pkg::OP_FIND, 8'd0, 32'sd0, 32'sd0);
    send_beat(sbis_pkg::OP_SPACING, 8'd0, 32'sd0, 32'sd0);
    write_register(sbis_pkg::CFG_POINT_COUNT, 31'd2);
    send_beat(sbis_pkg::OP_SPACING, 8'd0, 32'sd0, 32'sd0);
    send_beat(sbis_pkg::OP_FIND, 8'd0, X_MIN, 32'sd0);
    send_beat(sbis_pkg::OP_FIND, 8'd0, X_MAX, 32'sd0);
    // full signed range: gaps differ by one
    write_register(sbis_pkg::CFG_POINT_COUNT, 31'd3);
    send_beat(sbis_pkg::OP_SPACING, 8'd0, 32'sd0, 32'sd0);
    write_register(sbis_pkg::CFG_SPACING_TOL, 31'd1);
    send_beat(sbis_pkg::OP_SPACING, 8'd0, 32'sd0, 32'sd0);
    send_beat(sbis_pkg::OP_FIND, 8'd0, X_MAX, 32'sd0);
    send_beat(sbis_pkg::OP_WRITE, 8'd0, -32'sd5, 32'sd7);
    send_beat(sbis_pkg::OP_FIND, 8'd0, X_MIN, 32'sd0);
    // out-of-order table: one query still lands, one runs out of range
    send_beat(sbis_pkg::OP_WRITE, 8'd3, -32'sd100, 32'sd0);
    write_register(sbis_pkg::CFG_POINT_COUNT, 31'd4);
    send_beat(sbis_pkg::OP_FIND, 8'd0, 32'sd10, 32'sd0);
    send_beat(sbis_pkg::OP_FIND, 8'd0, -32'sd50, 32'sd0);
    send_beat(sbis_pkg::OP_SPACING, 8'd0, 32'sd0, 32'sd0);
    write_register(sbis_pkg::CFG_SPACING_TOL, TOL_MAX);
    send_beat(sbis_pkg::OP_SPACING, 8'd0, 32'sd0, 32'sd0);
  endtask

  task automatic test_random_tables(int beats);
    int start, pick, n;
    start = beats_sent;
    while (beats_sent - start < beats) begin
      pick = $urandom_range(99);
      n = (pick < 80) ? $urandom_range(0, 12) : (pick < 96) ? $urandom_range(13, 40) :
          $urandom_range(41, 96);
      run_scenario(n, $urandom_range(6, 20));
    end
  endtask

  task automatic test_full_table();
    longint jitter;
    load_table(MAX_POINTS, $urandom_range(1) ? SHAPE_EVEN : SHAPE_SORTED, jitter);
    pick_tolerance(jitter);
    write_register(sbis_pkg::CFG_POINT_COUNT, count_word(MAX_POINTS));
    repeat (12) random_op();
    send_beat(sbis_pkg::OP_SPACING, 8'd0, 32'sd0, 32'sd0);
    send_beat(sbis_pkg::OP_FIND, 8'd0, X_MAX, 32'sd0);
    send_beat(sbis_pkg::OP_READ, 8'd255, 32'sd0, 32'sd0);
    // counts past the table saturate
    write_register(sbis_pkg::CFG_POINT_COUNT, count_word(300));
    repeat (6) random_op();
    write_register(sbis_pkg::CFG_POINT_COUNT, 31'h7fff_ffff);
    send_beat(sbis_pkg::OP_SPACING, 8'd0, 32'sd0, 32'sd0);
    repeat (6) random_op();
    write_register(sbis_pkg::CFG_SPACING_TOL, TOL_MAX);
    send_beat(sbis_pkg::OP_SPACING, 8'd0, 32'sd0, 32'sd0);
    write_register(sbis_pkg::CFG_SPACING_TOL, '0);
    send_beat(sbis_pkg::OP_SPACING, 8'd0, 32'sd0, 32'sd0);
  endtask

  task automatic test_backpressure();
    write_register(sbis_pkg::CFG_POINT_COUNT, count_word(16));
    holdoff_req = 400;
    repeat (30) random_op();
  endtask

  // Result side: stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (holdoff_req != 0) begin
      holdoff_left = holdoff_req;
      holdoff_req = 0;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(string name, logic signed [DATA_W:0] want,
                             logic signed [DATA_W:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result beat with none expected: got x=%0d y=%0d idx=%0d found=%0b even=%0b",
                 $time, read_x, read_y, interval_index, found, equally_spaced);
      end else begin
        head = pending_results.pop_front();
        check_field("read_x", head.rx, read_x);
        check_field("read_y", head.ry, read_y);
        check_field("interval_index", head.seg, interval_index);
        check_field("found", head.hit, found);
        check_field("equally_spaced", head.even, equally_spaced);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 36;
    recv_idle_pct = 58;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_tables(250);
    send_idle_pct = 58;
    recv_idle_pct = 36;
    test_full_table();
    test_random_tables(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_tables(200);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
